// ----- rtl/sbpe_pkg.sv -----
// Package for the serial bootloader protocol engine.
// Holds payload structs, result/message codes and the controller/datapath command types.
// No dependencies.
package sbpe_pkg;

    localparam int ROW_WORDS = 32;
    localparam int ROW_BITS  = $clog2(ROW_WORDS);

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  msg_code;
        logic [12:0] flash_addr;
        logic [13:0] flash_word;
        logic        checksum_mode;
        logic [7:0]  device_kind;
        logic [15:0] mtu_size;
        logic [13:0] pace_delay;
        logic        last;
    } out_item_t;

    localparam logic [2:0] KIND_MSG    = 3'd0;
    localparam logic [2:0] KIND_LATCH  = 3'd1;
    localparam logic [2:0] KIND_COMMIT = 3'd2;
    localparam logic [2:0] KIND_ERASE  = 3'd3;
    localparam logic [2:0] KIND_VERIFY = 3'd4;

    localparam logic [3:0] MSG_INIT      = 4'd0;
    localparam logic [3:0] MSG_HS_TMO    = 4'd1;
    localparam logic [3:0] MSG_CFG_TMO   = 4'd2;
    localparam logic [3:0] MSG_CFG_OK    = 4'd3;
    localparam logic [3:0] MSG_ERASE_ST  = 4'd4;
    localparam logic [3:0] MSG_ERASE_END = 4'd5;
    localparam logic [3:0] MSG_WRITE_ST  = 4'd6;
    localparam logic [3:0] MSG_ACK       = 4'd7;
    localparam logic [3:0] MSG_PKT_TMO   = 4'd8;
    localparam logic [3:0] MSG_ERR_TMO   = 4'd9;
    localparam logic [3:0] MSG_WRITE_END = 4'd10;

    localparam logic [1:0] CFG_TICK_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_APP_START   = 2'd2;
    localparam logic [1:0] CFG_APP_END     = 2'd3;

    localparam logic [7:0] HS_FIRST  = 8'h55;
    localparam logic [7:0] HS_SECOND = 8'hAA;
    localparam int         CFG_BYTES = 4;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_HS_TICK   = 4'd1; // count a handshake tick
    localparam logic [3:0] OP_HS_BYTE   = 4'd2; // store prev byte
    localparam logic [3:0] OP_CFG_TICK  = 4'd3; // increment idle
    localparam logic [3:0] OP_CFG_BYTE  = 4'd4; // store a config byte
    localparam logic [3:0] OP_CFG_DONE  = 4'd5; // commit config fields
    localparam logic [3:0] OP_PKT_START = 4'd6; // load write_addr, clear counts
    localparam logic [3:0] OP_PKT_TICK  = 4'd7; // count a packet tick
    localparam logic [3:0] OP_PKT_BYTE  = 4'd8; // store a packet byte
    localparam logic [3:0] OP_PKT_TMO   = 4'd9; // clear partial packet, bump run
    localparam logic [3:0] OP_ROW_DONE  = 4'd10; // advance write_addr
    localparam logic [3:0] OP_HS_DONE   = 4'd11; // clear idle, cfg index

    typedef struct packed {
        logic [3:0]          op;
        logic [7:0]          data;
        logic [ROW_BITS-1:0] word_idx;   // read pair for a latch write
        logic                rd_en;
    } dp_cmd_t;

    typedef struct packed {
        logic        prev_is_first;
        logic        hs_tick_expire;  // count+1 >= limit
        logic        cfg_idle_at_lim; // count >= limit
        logic        cfg_last_byte;   // this byte completes config
        logic        req_program;     // request 0 or 1
        logic        pkt_tick_expire;
        logic        run_at_limit;    // after bump
        logic        pkt_last_byte;
        logic        area_end;        // next row passes app_end
        logic        checksum;
        logic [12:0] row_base;
        logic [13:0] word;
        logic [7:0]  device;
        logic [15:0] mtu;
        logic [13:0] pace_delay;
    } dp_status_t;

endpackage

// ----- rtl/sbpe_datapath.sv -----
// Datapath: protocol counters, config capture, packet buffer and word assembly.
// Depends on sbpe_pkg.
module sbpe_datapath
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [19:0] tick_limit,
    input  logic [3:0]  retry_limit,
    input  logic [12:0] app_start,
    input  logic [12:0] app_end,
    output dp_status_t  status
);
    localparam int PKT_BYTES = 2 * ROW_WORDS;
    localparam int BW = $clog2(PKT_BYTES);
    localparam int CW = $clog2(PKT_BYTES + 1);
    localparam int RB = $clog2(ROW_WORDS);

    logic [7:0]  prev_reg;
    logic [19:0] idle_reg;
    logic [1:0]  cfg_idx_reg;
    logic [7:0]  cfg_b0_reg, cfg_b1_reg, cfg_b2_reg;
    logic [7:0]  device_reg;
    logic [15:0] mtu_reg;
    logic [7:0]  request_reg;
    logic [CW-1:0] pkt_idx_reg;
    logic [12:0] waddr_reg;
    logic [3:0]  run_reg;
    logic [13:0] delay_reg;
    logic [7:0]  mem_lo [ROW_WORDS];
    logic [7:0]  mem_hi [ROW_WORDS];
    logic [7:0]  rd_lo_reg, rd_hi_reg;

    logic [19:0] idle_inc;
    logic [3:0]  run_inc;
    logic [15:0] new_mtu;
    logic [39:0] pace_prod;
    logic [13:0] next_addr;

    assign idle_inc = idle_reg + 20'd1;
    assign run_inc  = (run_reg == 4'hF) ? run_reg : run_reg + 4'd1;
    assign new_mtu  = {cfg_b1_reg, cfg_b2_reg};
    // size*211/1000 by reciprocal: size*14159971 >> 26 is exact for every 16-bit size
    assign pace_prod = {24'd0, mtu_reg} * 40'd14159971;
    assign next_addr = {1'b0, waddr_reg} + 14'(ROW_WORDS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            idle_reg    <= '0;
            cfg_idx_reg <= '0;
            cfg_b0_reg  <= '0;
            cfg_b1_reg  <= '0;
            cfg_b2_reg  <= '0;
            device_reg  <= 8'd1;
            mtu_reg     <= 16'd20;
            request_reg <= '0;
            pkt_idx_reg <= '0;
            waddr_reg   <= 13'd1792;
            run_reg     <= '0;
            delay_reg   <= 14'd20;
        end
        else
        begin
            delay_reg <= pace_prod[39:26] + 14'd16;
            unique case (cmd.op)
                OP_HS_TICK:  idle_reg <= idle_inc;
                OP_HS_BYTE:  prev_reg <= cmd.data;
                OP_HS_DONE:
                begin
                    idle_reg    <= '0;
                    cfg_idx_reg <= '0;
                end
                OP_CFG_TICK: idle_reg <= idle_inc;
                OP_CFG_BYTE:
                begin
                    idle_reg    <= '0;
                    cfg_idx_reg <= cfg_idx_reg + 2'd1;
                    unique case (cfg_idx_reg)
                        2'd0: cfg_b0_reg <= cmd.data;
                        2'd1: cfg_b1_reg <= cmd.data;
                        2'd2: cfg_b2_reg <= cmd.data;
                        default: ;
                    endcase
                end
                OP_CFG_DONE:
                begin
                    device_reg  <= cfg_b0_reg;
                    mtu_reg     <= new_mtu;
                    request_reg <= cmd.data;
                end
                OP_PKT_START:
                begin
                    waddr_reg   <= app_start;
                    run_reg     <= '0;
                    pkt_idx_reg <= '0;
                    idle_reg    <= '0;
                end
                OP_PKT_TICK: idle_reg <= idle_inc;
                OP_PKT_BYTE:
                begin
                    pkt_idx_reg <= pkt_idx_reg + CW'(1);
                    idle_reg    <= '0;
                end
                OP_PKT_TMO:
                begin
                    idle_reg    <= '0;
                    pkt_idx_reg <= '0;
                    run_reg     <= run_inc;
                end
                OP_ROW_DONE:
                begin
                    waddr_reg   <= next_addr[12:0];
                    pkt_idx_reg <= '0;
                    run_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

    // Packet buffer split into low/high byte memories, one write port each
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PKT_BYTE)
        begin
            if (pkt_idx_reg[0])
                mem_hi[pkt_idx_reg[BW-1:1]] <= cmd.data;
            else
                mem_lo[pkt_idx_reg[BW-1:1]] <= cmd.data;
        end
        if (cmd.rd_en)
        begin
            rd_lo_reg <= mem_lo[cmd.word_idx];
            rd_hi_reg <= mem_hi[cmd.word_idx];
        end
    end

    always_comb
    begin
        status.prev_is_first   = (prev_reg == HS_FIRST);
        status.hs_tick_expire  = (idle_inc >= tick_limit);
        status.cfg_idle_at_lim = (idle_reg >= tick_limit);
        status.cfg_last_byte   = (cfg_idx_reg == 2'(CFG_BYTES - 1));
        status.req_program     = (request_reg == 8'h00) || (request_reg == 8'h01);
        status.pkt_tick_expire = (idle_inc >= tick_limit);
        status.run_at_limit    = (run_inc >= retry_limit);
        status.pkt_last_byte   = (pkt_idx_reg == CW'(PKT_BYTES - 1));
        status.area_end        = (14'(next_addr + 14'(ROW_WORDS - 1)) > {1'b0, app_end})
                                 || (next_addr + 14'(ROW_WORDS - 1) < next_addr);
        status.checksum        = (request_reg == 8'h01) || (request_reg == 8'h03);
        status.row_base        = {waddr_reg[12:RB], {RB{1'b0}}};
        status.word            = {rd_hi_reg[5:0], rd_lo_reg};
        status.device          = device_reg;
        status.mtu             = mtu_reg;
        status.pace_delay      = delay_reg;
    end

endmodule

// ----- rtl/sbpe_controller.sv -----
// Controller state machine: decodes items, sequences result emission.
// Depends on sbpe_pkg.
module sbpe_controller
    import sbpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);
    localparam int RB = $clog2(ROW_WORDS);

    localparam logic [3:0] S_HS      = 4'd0;
    localparam logic [3:0] S_CFG     = 4'd1;
    localparam logic [3:0] S_PKT     = 4'd2;
    localparam logic [3:0] S_STOP    = 4'd3;
    localparam logic [3:0] S_CFGSEQ  = 4'd4; // cfg ok and program/verify messages
    localparam logic [3:0] S_ROWRD   = 4'd5; // read word pair
    localparam logic [3:0] S_ROWWR   = 4'd6; // emit latch write
    localparam logic [3:0] S_ROWEND  = 4'd7; // commit and trailing messages
    localparam logic [3:0] S_TMOSEQ  = 4'd8; // pkt timeout messages
    localparam logic [3:0] S_SINGLE  = 4'd9; // one message then return
    localparam logic [3:0] S_DELAY   = 4'd10; // wait for config fields to settle

    logic [3:0]  state_reg, state_next;
    logic [3:0]  ret_reg, ret_next;
    logic [2:0]  step_reg, step_next;
    logic [RB:0] widx_reg, widx_next;
    logic [3:0]  smsg_reg, smsg_next;
    logic        prog_reg, prog_next;
    logic        endf_reg, endf_next;
    logic        stop_reg, stop_next;
    logic        ov_reg;
    out_item_t   od_reg;
    logic        emit;
    out_item_t   e;
    logic        slot_free;

    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        step_next  = step_reg;
        widx_next  = widx_reg;
        smsg_next  = smsg_reg;
        prog_next  = prog_reg;
        endf_next  = endf_reg;
        stop_next  = stop_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        cmd        = '0;
        e          = '0;
        e.device_kind = status.device;
        e.mtu_size    = status.mtu;
        e.pace_delay  = status.pace_delay;
        unique case (state_reg)
            S_HS, S_CFG, S_PKT, S_STOP:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.data = in_data.rx_byte;
                    unique case (state_reg)
                        S_HS:
                        begin
                            if (in_data.cmd)
                            begin
                                cmd.op = OP_HS_TICK;
                                if (status.hs_tick_expire)
                                begin
                                    smsg_next = MSG_HS_TMO; stop_next = 1'b1;
                                    state_next = S_SINGLE;
                                end
                            end
                            else if (status.prev_is_first && in_data.rx_byte == HS_SECOND)
                            begin
                                cmd.op = OP_HS_DONE;
                                smsg_next = MSG_INIT; stop_next = 1'b0;
                                ret_next = S_CFG; state_next = S_SINGLE;
                            end
                            else
                                cmd.op = OP_HS_BYTE;
                        end
                        S_CFG:
                        begin
                            if (in_data.cmd)
                            begin
                                if (status.cfg_idle_at_lim)
                                begin
                                    smsg_next = MSG_CFG_TMO; stop_next = 1'b1;
                                    state_next = S_SINGLE;
                                end
                                else
                                    cmd.op = OP_CFG_TICK;
                            end
                            else if (status.cfg_last_byte)
                            begin
                                cmd.op = OP_CFG_DONE;
                                step_next = '0; state_next = S_DELAY;
                            end
                            else
                                cmd.op = OP_CFG_BYTE;
                        end
                        S_PKT:
                        begin
                            if (in_data.cmd)
                            begin
                                if (status.pkt_tick_expire)
                                begin
                                    prog_next = status.run_at_limit;
                                    cmd.op = OP_PKT_TMO; step_next = '0;
                                    state_next = S_TMOSEQ;
                                end
                                else
                                    cmd.op = OP_PKT_TICK;
                            end
                            else
                            begin
                                cmd.op = OP_PKT_BYTE;
                                if (status.pkt_last_byte)
                                begin
                                    widx_next = '0; state_next = S_ROWRD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SINGLE:
            begin
                if (slot_free)
                begin
                    emit = 1'b1; e.msg_code = smsg_reg; e.last = 1'b1;
                    state_next = stop_reg ? S_STOP : ret_reg;
                end
            end
            S_DELAY:
            begin
                // settle state so the pacing delay reflects the new MTU
                prog_next = status.req_program;
                step_next = '0;
                state_next = S_CFGSEQ;
            end
            S_CFGSEQ:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        e.msg_code = MSG_CFG_OK;
                        if (!prog_reg)
                            step_next = 3'd6;
                    end
                    else if (step_reg == 3'd1)
                        e.msg_code = MSG_ERASE_ST;
                    else if (step_reg == 3'd2)
                        e.kind = KIND_ERASE;
                    else if (step_reg == 3'd3)
                        e.msg_code = MSG_ERASE_END;
                    else if (step_reg == 3'd4)
                        e.msg_code = MSG_WRITE_ST;
                    else if (step_reg == 3'd5)
                    begin
                        e.msg_code = MSG_ACK; e.last = 1'b1;
                        cmd.op = OP_PKT_START; state_next = S_PKT;
                    end
                    else
                    begin
                        e.kind = KIND_VERIFY; e.checksum_mode = status.checksum;
                        e.last = 1'b1; state_next = S_STOP;
                    end
                end
            end
            S_TMOSEQ:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd0)
                        e.msg_code = MSG_PKT_TMO;
                    else
                    begin
                        e.msg_code = prog_reg ? MSG_ERR_TMO : MSG_ACK;
                        e.last = 1'b1;
                        state_next = prog_reg ? S_STOP : S_PKT;
                    end
                end
            end
            S_ROWRD:
            begin
                cmd.rd_en = 1'b1;
                cmd.word_idx = widx_reg[RB-1:0];
                state_next = S_ROWWR;
            end
            S_ROWWR:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    e.kind = KIND_LATCH;
                    e.flash_addr = status.row_base | 13'(widx_reg[RB-1:0]);
                    e.flash_word = status.word;
                    widx_next = widx_reg + (RB+1)'(1);
                    step_next = '0;
                    state_next = (widx_reg == (RB+1)'(ROW_WORDS - 1)) ? S_ROWEND : S_ROWRD;
                end
            end
            S_ROWEND:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        e.kind = KIND_COMMIT; e.flash_addr = status.row_base;
                        endf_next = status.area_end;
                        cmd.op = OP_ROW_DONE;
                    end
                    else if (!endf_reg)
                    begin
                        e.msg_code = MSG_ACK; e.last = 1'b1; state_next = S_PKT;
                    end
                    else if (step_reg == 3'd1)
                        e.msg_code = MSG_WRITE_END;
                    else
                    begin
                        e.kind = KIND_VERIFY; e.checksum_mode = status.checksum;
                        e.last = 1'b1; state_next = S_STOP;
                    end
                end
            end
            default: state_next = S_STOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HS;
            ret_reg   <= S_HS;
            step_reg  <= '0;
            widx_reg  <= '0;
            smsg_reg  <= '0;
            prog_reg  <= 1'b0;
            endf_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            step_reg  <= step_next;
            widx_reg  <= widx_next;
            smsg_reg  <= smsg_next;
            prog_reg  <= prog_next;
            endf_reg  <= endf_next;
            stop_reg  <= stop_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            od_reg <= e;
    end

    // Item intake only in the four resting states
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_HS || state_reg == S_CFG ||
                      state_reg == S_PKT || state_reg == S_STOP))
        else $error("intake outside resting state");
    // Latch writes only from the row emitter
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e.kind == KIND_LATCH) |-> state_reg == S_ROWWR)
        else $error("latch write outside row emission");
    // Stopped engine emits nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STOP |-> !emit)
        else $error("emission after stop");

endmodule

// ----- rtl/serial_bootloader_protocol_engine.sv -----
// Top level of the serial bootloader protocol engine.
// Holds the configuration registers and joins sbpe_controller and sbpe_datapath; uses sbpe_pkg.
//
// Usage: feed received UART bytes (cmd=0) and idle poll ticks (cmd=1) as input
// transactions. Each transaction yields zero or more result transactions, the
// final one flagged with last. A row holds ROW_WORDS (32) words, fixed in the
// package. A byte or tick with no results leaves the engine ready for input;
// one that produces results blocks further input until its results are
// emitted, one message per cycle with out_ready high: the handshake or a config
// timeout yields one message, a packet timeout two, the last config byte a
// settle step for the pacing delay and then its messages, and a completed
// packet a buffer read and a latch write per word, then commit and ack (write
// end and verify in place of ack at the end of the area). Results pass through
// one output register, so input is never held by a stalled consumer while the
// engine rests; output stalls lengthen these sequences. Configuration writes
// are accepted any cycle and must occur only while the engine is idle.
module serial_bootloader_protocol_engine
    import sbpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    logic [19:0] tick_limit_reg;
    logic [3:0]  retry_limit_reg;
    logic [12:0] app_start_reg;
    logic [12:0] app_end_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign cfg_ready = 1'b1;

    // Hold configuration; it must be written only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg  <= 20'd1000000;
            retry_limit_reg <= 4'd3;
            app_start_reg   <= 13'd1792;
            app_end_reg     <= 13'd8191;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TICK_LIMIT:  tick_limit_reg  <= cfg_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[3:0];
                CFG_APP_START:   app_start_reg   <= cfg_data[12:0];
                CFG_APP_END:     app_end_reg     <= cfg_data[12:0];
            endcase
        end
    end

    sbpe_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (status),
        .cmd       (cmd)
    );

    sbpe_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .tick_limit  (tick_limit_reg),
        .retry_limit (retry_limit_reg),
        .app_start   (app_start_reg),
        .app_end     (app_end_reg),
        .status      (status)
    );

endmodule
